/* rtl/aolt_pkg.sv */
// Shared constants, codes and types for the axis ownership lock table.
`default_nettype none

package aolt_pkg;

    localparam int SLOTS  = 16;
    localparam int JOINTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int OPCODE_W  = 3;
    localparam int KEY_W     = 16;
    localparam int JOINT_W   = 4;
    localparam int CHAN_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int SLOTF_W   = 4;
    localparam int DEPTH_W   = 8;
    localparam int NJOINTS_W = 5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [DEPTH_W-1:0]   DEPTH_MAX      = 8'd255;
    localparam logic [NJOINTS_W-1:0] NUM_JOINTS_RST = 5'd16;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_DEFINE  = 3'd0,
        OP_ACQUIRE = 3'd1,
        OP_RELEASE = 3'd2,
        OP_LOOKUP  = 3'd3,
        OP_QUERY   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_UNKNOWN    = 3'd1,
        ST_BUSY       = 3'd2,
        ST_NOT_OWNER  = 3'd3,
        ST_DUP        = 3'd4,
        ST_JOINT_USED = 3'd5,
        ST_FULL       = 3'd6
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch the incoming transfer
        logic exec;   // run the command, update table, load result
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/aolt_ctrl.sv */
// Controller: sequences accept, execute and result hand-off.
`default_nettype none

module aolt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output aolt_pkg::cmd_t     cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // result slot is free if empty or drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC)
        else $error("accepted transfer not followed by execute state");

    a_exec_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("executed command produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and execute in the same cycle");

endmodule

`default_nettype wire

/* rtl/aolt_dp.sv */
// Datapath: slot table, parallel key/joint match, command execution, result register.
`default_nettype none

module aolt_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire aolt_pkg::cmd_t                        cmd,
    input  wire logic [aolt_pkg::IN_DATA_W-1:0]        in_data,
    input  wire logic                                  cfg_we,
    input  wire logic [aolt_pkg::NJOINTS_W-1:0]        cfg_data,
    output logic [aolt_pkg::OUT_DATA_W-1:0]            out_data
);

    localparam int SLOTS  = aolt_pkg::SLOTS;
    localparam int SLOT_W = aolt_pkg::SLOT_W;

    // lowest set bit of a slot vector
    function automatic aolt_pkg::slot_idx_t first_set(input logic [SLOTS-1:0] v);
        aolt_pkg::slot_idx_t idx;
        idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (v[s])
                idx = aolt_pkg::slot_idx_t'(s);
        end
        return idx;
    endfunction

    // slot index as carried on the result, low bits only
    function automatic logic [aolt_pkg::SLOTF_W-1:0] slot_field(
        input aolt_pkg::slot_idx_t i);
        logic [SLOT_W+aolt_pkg::SLOTF_W-1:0] w;
        w = {{aolt_pkg::SLOTF_W{1'b0}}, i};
        return w[aolt_pkg::SLOTF_W-1:0];
    endfunction

    // latched command
    logic [aolt_pkg::OPCODE_W-1:0]  op_reg;
    logic [aolt_pkg::KEY_W-1:0]     key_reg;
    logic [aolt_pkg::JOINT_W-1:0]   joint_reg;
    logic [aolt_pkg::CHAN_W-1:0]    chan_reg;
    logic [aolt_pkg::NJOINTS_W-1:0] num_joints_reg;

    // slot table
    logic [SLOTS-1:0]               slot_valid_reg;
    logic [aolt_pkg::KEY_W-1:0]     slot_key_reg   [SLOTS];
    logic [aolt_pkg::JOINT_W-1:0]   slot_joint_reg [SLOTS];
    logic [aolt_pkg::CHAN_W-1:0]    slot_owner_reg [SLOTS];
    logic [aolt_pkg::DEPTH_W-1:0]   slot_depth_reg [SLOTS];

    logic [aolt_pkg::OUT_DATA_W-1:0] result_reg;
    logic [aolt_pkg::OUT_DATA_W-1:0] result_next;

    logic [SLOTS-1:0]               key_hit;
    logic [SLOTS-1:0]               joint_hit;
    logic                           key_any;
    logic                           joint_any;
    logic                           free_any;
    aolt_pkg::slot_idx_t            key_idx;
    aolt_pkg::slot_idx_t            joint_idx;
    aolt_pkg::slot_idx_t            free_idx;
    aolt_pkg::slot_idx_t            rd_idx;
    aolt_pkg::slot_idx_t            rep_idx;
    aolt_pkg::slot_idx_t            wr_idx;
    logic [aolt_pkg::CHAN_W-1:0]    cur_owner;
    logic [aolt_pkg::DEPTH_W-1:0]   cur_depth;
    logic [aolt_pkg::CHAN_W-1:0]    new_owner;
    logic [aolt_pkg::DEPTH_W-1:0]   new_depth;
    logic                           joint_ok;
    logic                           wr_def;
    logic                           wr_own;
    logic                           hit;
    aolt_pkg::status_t              status;

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            key_hit[s]   = slot_valid_reg[s] && (slot_key_reg[s] == key_reg);
            joint_hit[s] = slot_valid_reg[s] && (slot_joint_reg[s] == joint_reg);
        end
    end

    assign key_any   = |key_hit;
    assign joint_any = |joint_hit;
    assign free_any  = ~&slot_valid_reg;
    assign key_idx   = first_set(key_hit);
    assign joint_idx = first_set(joint_hit);
    assign free_idx  = first_set(~slot_valid_reg);

    // one table read: joint match for the query, key match otherwise
    assign rd_idx    = (op_reg == aolt_pkg::OP_QUERY) ? joint_idx : key_idx;
    assign cur_owner = slot_owner_reg[rd_idx];
    assign cur_depth = slot_depth_reg[rd_idx];

    assign joint_ok = ({1'b0, joint_reg} < num_joints_reg)
                   && ({28'd0, joint_reg} < 32'(aolt_pkg::JOINTS));

    always_comb
    begin
        status    = aolt_pkg::ST_OK;
        hit       = 1'b0;
        wr_def    = 1'b0;
        wr_own    = 1'b0;
        new_owner = cur_owner;
        new_depth = cur_depth;
        rep_idx   = key_idx;
        case (op_reg)
            aolt_pkg::OP_DEFINE:
            begin
                if (key_any)
                    status = aolt_pkg::ST_DUP;
                else if (joint_any)
                    status = aolt_pkg::ST_JOINT_USED;
                else if (!free_any)
                    status = aolt_pkg::ST_FULL;
                else
                begin
                    wr_def    = 1'b1;
                    hit       = 1'b1;
                    rep_idx   = free_idx;
                    new_owner = '0;
                    new_depth = '0;
                end
            end
            aolt_pkg::OP_ACQUIRE:
            begin
                if (!key_any)
                    status = aolt_pkg::ST_UNKNOWN;
                else if (chan_reg == '0)
                    status = aolt_pkg::ST_BUSY;
                else if (cur_owner == '0)
                begin
                    new_owner = chan_reg;
                    new_depth = 8'd1;
                    wr_own    = 1'b1;
                    hit       = 1'b1;
                end
                else if (cur_owner == chan_reg)
                begin
                    if (cur_depth != aolt_pkg::DEPTH_MAX)
                        new_depth = cur_depth + 8'd1;
                    wr_own = 1'b1;
                    hit    = 1'b1;
                end
                else
                    status = aolt_pkg::ST_BUSY;
            end
            aolt_pkg::OP_RELEASE:
            begin
                if (!key_any)
                    status = aolt_pkg::ST_UNKNOWN;
                else if ((chan_reg == '0) || (cur_owner != chan_reg))
                    status = aolt_pkg::ST_NOT_OWNER;
                else
                begin
                    if (cur_depth > 8'd1)
                        new_depth = cur_depth - 8'd1;
                    else
                    begin
                        new_owner = '0;
                        new_depth = '0;
                    end
                    wr_own = 1'b1;
                    hit    = 1'b1;
                end
            end
            aolt_pkg::OP_LOOKUP:
            begin
                if (!key_any)
                    status = aolt_pkg::ST_UNKNOWN;
                else
                    hit = 1'b1;
            end
            aolt_pkg::OP_QUERY:
            begin
                if (joint_ok && joint_any)
                begin
                    hit     = 1'b1;
                    rep_idx = joint_idx;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign wr_idx = wr_def ? free_idx : key_idx;

    assign result_next = {
        1'b0,
        hit ? new_depth : {aolt_pkg::DEPTH_W{1'b0}},
        hit ? new_owner : {aolt_pkg::CHAN_W{1'b0}},
        hit ? slot_field(rep_idx) : {aolt_pkg::SLOTF_W{1'b0}},
        status
    };

    assign out_data = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            num_joints_reg <= aolt_pkg::NUM_JOINTS_RST;
        end
        else
        begin
            if (cfg_we)
                num_joints_reg <= cfg_data;
            if (cmd.exec && wr_def)
                slot_valid_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_data[2:0];
            key_reg   <= in_data[18:3];
            joint_reg <= in_data[22:19];
            chan_reg  <= in_data[30:23];
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
            if (wr_def)
            begin
                slot_key_reg[free_idx]   <= key_reg;
                slot_joint_reg[free_idx] <= joint_reg;
            end
            if (wr_def || wr_own)
            begin
                slot_owner_reg[wr_idx] <= new_owner;
                slot_depth_reg[wr_idx] <= new_depth;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/axis_ownership_lock_table_core.sv */
// Top level of the axis ownership lock table.
//
// Usage:
//   s_* channel carries one command per transfer (define, acquire, release,
//   lookup axis, query joint owner). m_* channel returns exactly one result
//   transfer per command, in command order.
//   cfg_we/cfg_data write num_joints (joints below it answer the owner
//   query); write only while no command is outstanding.
// Timing:
//   A command is accepted in idle and executed in the execute state, where all
//   slots are matched in parallel and the table is updated; execute waits while
//   a held result has not been taken. The result is registered at execute. A new
//   command is not accepted until the previous one has executed.
// Reset:
//   All slots become undefined (valid bits cleared), num_joints returns to 16,
//   no result is pending.
// Backpressure:
//   A held result stays in the output register; one more command may be
//   accepted meanwhile and waits in execute until the result is taken.
`default_nettype none

module axis_ownership_lock_table_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [2:0] opcode, [18:3] axis_id, [22:19] joint_number, [30:23] channel
    input  wire logic [aolt_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] status, [6:3] slot_index, [14:7] owner_channel, [22:15] lock_depth
    output logic [aolt_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [aolt_pkg::NJOINTS_W-1:0]      cfg_data
);

    aolt_pkg::cmd_t cmd;

    aolt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    aolt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the axis ownership lock table core.
`timescale 1ns / 1ps

module tb_top;

    // opcodes with no command behind them; they must answer ok with empty fields
    localparam logic [aolt_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [aolt_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int KEY_POOL = 24;

    typedef struct packed {
        logic                          pad;
        logic [aolt_pkg::CHAN_W-1:0]   channel;
        logic [aolt_pkg::JOINT_W-1:0]  joint;
        logic [aolt_pkg::KEY_W-1:0]    axis_id;
        logic [aolt_pkg::OPCODE_W-1:0] opcode;
    } lock_cmd_t;

    typedef struct packed {
        logic                          pad;
        logic [aolt_pkg::DEPTH_W-1:0]  lock_depth;
        logic [aolt_pkg::CHAN_W-1:0]   owner_channel;
        logic [aolt_pkg::SLOTF_W-1:0]  slot_index;
        aolt_pkg::status_t             status;
    } lock_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // [2:0] opcode, [18:3] axis_id, [22:19] joint_number, [30:23] channel
    logic [aolt_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // [2:0] status, [6:3] slot_index, [14:7] owner_channel, [22:15] lock_depth
    logic [aolt_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we;
    logic [aolt_pkg::NJOINTS_W-1:0]  cfg_data;

    axis_ownership_lock_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow copy of the table
    logic                           tbl_valid [aolt_pkg::SLOTS];
    logic [aolt_pkg::KEY_W-1:0]     tbl_key   [aolt_pkg::SLOTS];
    logic [aolt_pkg::JOINT_W-1:0]   tbl_joint [aolt_pkg::SLOTS];
    logic [aolt_pkg::CHAN_W-1:0]    tbl_owner [aolt_pkg::SLOTS];
    logic [aolt_pkg::DEPTH_W-1:0]   tbl_depth [aolt_pkg::SLOTS];
    logic [aolt_pkg::NJOINTS_W-1:0] joint_limit;

    lock_result_t pending_results [$];
    logic [aolt_pkg::KEY_W-1:0] axis_keys [KEY_POOL];
    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;
    lock_result_t got_result;
    lock_result_t want_result;

    function automatic int find_axis(logic [aolt_pkg::KEY_W-1:0] key);
        for (int i = 0; i < aolt_pkg::SLOTS; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int find_joint(logic [aolt_pkg::JOINT_W-1:0] j);
        for (int i = 0; i < aolt_pkg::SLOTS; i++)
            if (tbl_valid[i] && tbl_joint[i] == j)
                return i;
        return -1;
    endfunction

    // negative slot means an empty result (errors, unbound joints)
    function automatic lock_result_t slot_result(aolt_pkg::status_t st, int s);
        lock_result_t r;
        r = '0;
        r.status = st;
        if (s >= 0)
        begin
            r.slot_index    = s[aolt_pkg::SLOTF_W-1:0];
            r.owner_channel = tbl_owner[s];
            r.lock_depth    = tbl_depth[s];
        end
        return r;
    endfunction

    function automatic lock_result_t predict_lock_result(lock_cmd_t c);
        int s;
        s = find_axis(c.axis_id);
        case (c.opcode)
            aolt_pkg::OP_DEFINE:
            begin
                if (s >= 0)
                    return slot_result(aolt_pkg::ST_DUP, -1);
                if (find_joint(c.joint) >= 0)
                    return slot_result(aolt_pkg::ST_JOINT_USED, -1);
                for (int i = 0; i < aolt_pkg::SLOTS; i++)
                    if (!tbl_valid[i])
                    begin
                        tbl_valid[i] = 1'b1;
                        tbl_key[i]   = c.axis_id;
                        tbl_joint[i] = c.joint;
                        tbl_owner[i] = '0;
                        tbl_depth[i] = '0;
                        return slot_result(aolt_pkg::ST_OK, i);
                    end
                return slot_result(aolt_pkg::ST_FULL, -1);
            end
            aolt_pkg::OP_ACQUIRE:
            begin
                if (s < 0)
                    return slot_result(aolt_pkg::ST_UNKNOWN, -1);
                if (c.channel == 0)
                    return slot_result(aolt_pkg::ST_BUSY, -1);
                if (tbl_owner[s] == 0)
                begin
                    tbl_owner[s] = c.channel;
                    tbl_depth[s] = 8'd1;
                    return slot_result(aolt_pkg::ST_OK, s);
                end
                if (tbl_owner[s] == c.channel)
                begin
                    if (tbl_depth[s] < aolt_pkg::DEPTH_MAX)
                        tbl_depth[s] = tbl_depth[s] + 1'b1;
                    return slot_result(aolt_pkg::ST_OK, s);
                end
                return slot_result(aolt_pkg::ST_BUSY, -1);
            end
            aolt_pkg::OP_RELEASE:
            begin
                if (s < 0)
                    return slot_result(aolt_pkg::ST_UNKNOWN, -1);
                if (c.channel == 0 || tbl_owner[s] != c.channel)
                    return slot_result(aolt_pkg::ST_NOT_OWNER, -1);
                if (tbl_depth[s] > 1)
                    tbl_depth[s] = tbl_depth[s] - 1'b1;
                else
                begin
                    tbl_owner[s] = '0;
                    tbl_depth[s] = '0;
                end
                return slot_result(aolt_pkg::ST_OK, s);
            end
            aolt_pkg::OP_LOOKUP:
            begin
                if (s < 0)
                    return slot_result(aolt_pkg::ST_UNKNOWN, -1);
                return slot_result(aolt_pkg::ST_OK, s);
            end
            aolt_pkg::OP_QUERY:
            begin
                if (c.joint >= joint_limit || c.joint >= aolt_pkg::JOINTS)
                    return slot_result(aolt_pkg::ST_OK, -1);
                return slot_result(aolt_pkg::ST_OK, find_joint(c.joint));
            end
            default:
                return slot_result(aolt_pkg::ST_OK, -1);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // valid is left high after a transfer so back-to-back commands need no toggle
    task automatic send_lock_cmd(input logic [aolt_pkg::OPCODE_W-1:0] op,
                                 input logic [aolt_pkg::KEY_W-1:0] key,
                                 input logic [aolt_pkg::JOINT_W-1:0] joint,
                                 input logic [aolt_pkg::CHAN_W-1:0] ch);
        lock_cmd_t c;
        c = '0;
        c.opcode  = op;
        c.axis_id = key;
        c.joint   = joint;
        c.channel = ch;
        if ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_lock_result(c));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_joint_limit(input logic [aolt_pkg::NJOINTS_W-1:0] value);
        wait_results_drained();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        joint_limit = value;
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = m_tdata;
            if (pending_results.size() == 0)
                report_mismatch("result with no command pending", got_result, 0);
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.status != want_result.status)
                    report_mismatch("status", got_result.status, want_result.status);
                if (got_result.slot_index != want_result.slot_index)
                    report_mismatch("slot_index", got_result.slot_index,
                                    want_result.slot_index);
                if (got_result.owner_channel != want_result.owner_channel)
                    report_mismatch("owner_channel", got_result.owner_channel,
                                    want_result.owner_channel);
                if (got_result.lock_depth != want_result.lock_depth)
                    report_mismatch("lock_depth", got_result.lock_depth,
                                    want_result.lock_depth);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("axis_ownership_lock_table_core regression: fail");
                $finish;
            end
        end
    end

    task automatic test_define();
        send_lock_cmd(aolt_pkg::OP_DEFINE, 16'h0000, 4'd0, 8'd0);
        send_lock_cmd(aolt_pkg::OP_DEFINE, 16'hFFFF, 4'd15, 8'd255);
        send_lock_cmd(aolt_pkg::OP_DEFINE, 16'h0000, 4'd3, 8'd0);    // duplicate key
        send_lock_cmd(aolt_pkg::OP_DEFINE, 16'h1234, 4'd15, 8'd0);   // joint taken
    endtask

    task automatic test_acquire_release();
        send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd0, 8'd0);   // channel none
        send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd0, 8'd255);
        send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd0, 8'd255);
        send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd0, 8'd1);   // held by another
        send_lock_cmd(aolt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, 8'd0);
        send_lock_cmd(aolt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, 8'd1);
        send_lock_cmd(aolt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, 8'd255);
        send_lock_cmd(aolt_pkg::OP_LOOKUP, 16'hFFFF, 4'd0, 8'd0);
        send_lock_cmd(aolt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, 8'd255);
        send_lock_cmd(aolt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, 8'd255); // already free
        send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'h4321, 4'd0, 8'd7);
        send_lock_cmd(aolt_pkg::OP_RELEASE, 16'h4321, 4'd0, 8'd7);
        send_lock_cmd(aolt_pkg::OP_LOOKUP, 16'h4321, 4'd0, 8'd0);
        send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'h0000, 4'd0, 8'd128);
    endtask

    task automatic test_joint_query();
        send_lock_cmd(aolt_pkg::OP_QUERY, 16'h0000, 4'd0, 8'd0);
        send_lock_cmd(aolt_pkg::OP_QUERY, 16'h0000, 4'd15, 8'd0);
        send_lock_cmd(aolt_pkg::OP_QUERY, 16'h0000, 4'd7, 8'd0);     // no axis bound
        write_joint_limit(5'd0);
        send_lock_cmd(aolt_pkg::OP_QUERY, 16'h0000, 4'd0, 8'd0);
        write_joint_limit(aolt_pkg::NUM_JOINTS_RST);
    endtask

    task automatic test_spare_opcodes();
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_lock_cmd(op[aolt_pkg::OPCODE_W-1:0], 16'hFFFF, 4'd15, 8'd255);
    endtask

    // drive one axis past the depth ceiling, then unwind it completely
    task automatic test_depth_saturation();
        src_gap_pct = 21;
        sink_stall_pct = 21;
        send_lock_cmd(aolt_pkg::OP_DEFINE, 16'h8001, 4'd8, 8'd0);
        for (int i = 0; i < 258; i++)
            send_lock_cmd(aolt_pkg::OP_ACQUIRE, 16'h8001, 4'd0, 8'd42);
        for (int i = 0; i < 256; i++)
            send_lock_cmd(aolt_pkg::OP_RELEASE, 16'h8001, 4'd0, 8'd42);
        src_gap_pct = 0;
        sink_stall_pct = 0;
    endtask

    function automatic logic [aolt_pkg::CHAN_W-1:0] pick_channel();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return 8'd1;
            3, 4:    return 8'd2;
            5:       return 8'd255;
            6:       return 8'd3;
            default: return aolt_pkg::CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [aolt_pkg::NJOINTS_W-1:0] limit,
                                       input int count);
        int pick;
        logic [aolt_pkg::KEY_W-1:0] key;
        logic [aolt_pkg::JOINT_W-1:0] jnt;
        write_joint_limit(limit);
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(19) == 0)
                key = aolt_pkg::KEY_W'($urandom_range(65535));
            else
                key = axis_keys[$urandom_range(KEY_POOL - 1)];
            jnt = aolt_pkg::JOINT_W'($urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 14)
                send_lock_cmd(aolt_pkg::OP_DEFINE, key, jnt, pick_channel());
            else if (pick < 44)
                send_lock_cmd(aolt_pkg::OP_ACQUIRE, key, jnt, pick_channel());
            else if (pick < 74)
                send_lock_cmd(aolt_pkg::OP_RELEASE, key, jnt, pick_channel());
            else if (pick < 84)
                send_lock_cmd(aolt_pkg::OP_LOOKUP, key, jnt, pick_channel());
            else if (pick < 97)
                send_lock_cmd(aolt_pkg::OP_QUERY, key, jnt, pick_channel());
            else
                send_lock_cmd(aolt_pkg::OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                              key, jnt, pick_channel());
            if ($urandom_range(63) == 0)
                wait_results_drained();
        end
        src_gap_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = aolt_pkg::NUM_JOINTS_RST;
        joint_limit = aolt_pkg::NUM_JOINTS_RST;
        for (int i = 0; i < aolt_pkg::SLOTS; i++)
            tbl_valid[i] = 1'b0;
        axis_keys[0] = 16'h0000;
        axis_keys[1] = 16'hFFFF;
        for (int i = 2; i < KEY_POOL; i++)
            axis_keys[i] = aolt_pkg::KEY_W'($urandom_range(65535));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_define();
        test_acquire_release();
        test_joint_query();
        test_spare_opcodes();
        test_depth_saturation();
        // a full table is unreachable: sixteen slots hold all sixteen joints,
        // so a new define always fails on the joint first
        test_random_traffic(0, 0, aolt_pkg::NUM_JOINTS_RST, 170);
        test_random_traffic(48, 0, 5'd0, 170);
        test_random_traffic(0, 48, 5'd9, 170);
        test_random_traffic(21, 21, 5'd15, 170);

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (error_count == 0)
            $display("axis_ownership_lock_table_core regression: pass");
        else
            $display("axis_ownership_lock_table_core regression: fail");
        $finish;
    end

endmodule
